// File: hdl/wsdf_pkg.sv
package wsdf_pkg;

  // Defaults for the top-level parameters
  localparam int LEN_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Frame opcodes
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Byte counts of the extended length and of the mask key
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_EMPTY    = 2'd1,
    EV_CLOSE    = 2'd2,
    EV_OVERSIZE = 2'd3
  } ev_kind_t;

  // One classified event from the parser to the output side
  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] rx_byte;   // raw payload byte, zero for non-data events
    logic [7:0] key_byte;  // mask key lane for this byte
    logic [3:0] opcode;
    logic       last;
  } ev_item_t;

endpackage

// File: hdl/wsdf_front.sv
module wsdf_front #(
  parameter int LEN_BITS = wsdf_pkg::LEN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_acc,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               push,
  output wsdf_pkg::ev_item_t push_item
);

  localparam int CMP_W = (LEN_BITS > 16) ? LEN_BITS : 16;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [3:0]          op_r, op_nxt;
  logic                mask_r, mask_nxt;
  logic [3:0]          ext_r, ext_nxt;
  logic [LEN_BITS-1:0] acc_r, acc_nxt;
  logic                ovf_r, ovf_nxt;
  logic [31:0]         key_r, key_nxt;
  logic [1:0]          lane_r, lane_nxt;
  logic [LEN_BITS-1:0] rem_r, rem_nxt;
  logic                stop_r, stop_nxt;
  logic [15:0]         max_len_r;

  logic                len_done;
  logic                hdr_done;
  logic                data_last;
  logic [7:0]          key_lane_byte;
  logic [LEN_BITS+7:0] acc_shift;

  assign acc_shift = {acc_r, rx_byte};

  always_comb begin
    case (lane_r)
      2'd0:    key_lane_byte = key_r[31:24];
      2'd1:    key_lane_byte = key_r[23:16];
      2'd2:    key_lane_byte = key_r[15:8];
      default: key_lane_byte = key_r[7:0];
    endcase
  end

  assign data_last = (rem_r <= LEN_BITS'(1));

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    mask_nxt  = mask_r;
    ext_nxt   = ext_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    key_nxt   = key_r;
    lane_nxt  = lane_r;
    rem_nxt   = rem_r;
    stop_nxt  = stop_r;
    len_done  = 1'b0;
    hdr_done  = 1'b0;
    push      = 1'b0;
    push_item = '{kind: wsdf_pkg::EV_DATA, rx_byte: 8'h00, key_byte: 8'h00,
                  opcode: op_r, last: 1'b1};

    if (byte_acc && !stop_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          op_nxt    = rx_byte[3:0];
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          mask_nxt = rx_byte[7];
          key_nxt  = 32'h0;
          ovf_nxt  = 1'b0;
          if (rx_byte[6:0] == wsdf_pkg::LEN7_EXT16 ||
              rx_byte[6:0] == wsdf_pkg::LEN7_EXT64) begin
            ext_nxt   = (rx_byte[6:0] == wsdf_pkg::LEN7_EXT16) ?
                        wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
            acc_nxt   = '0;
            phase_nxt = PH_EXT;
          end else begin
            acc_nxt  = LEN_BITS'(rx_byte[6:0]);
            len_done = 1'b1;
          end
        end
        PH_EXT: begin
          // flag any bits shifted out above the length width
          ovf_nxt = ovf_r | (acc_r[LEN_BITS-1 -: 8] != 8'h00);
          acc_nxt = acc_shift[LEN_BITS-1:0];
          ext_nxt = ext_r - 4'd1;
          len_done = (ext_nxt == 4'd0);
        end
        PH_KEY: begin
          key_nxt  = {key_r[23:0], rx_byte};
          ext_nxt  = ext_r - 4'd1;
          hdr_done = (ext_nxt == 4'd0);
        end
        PH_DATA: begin
          lane_nxt = lane_r + 2'd1;
          rem_nxt  = data_last ? '0 : rem_r - LEN_BITS'(1);
          if (data_last) begin
            phase_nxt = PH_HDR0;
          end
          if (op_r == wsdf_pkg::OP_TEXT || op_r == wsdf_pkg::OP_PING) begin
            push               = 1'b1;
            push_item.kind     = wsdf_pkg::EV_DATA;
            push_item.rx_byte  = rx_byte;
            push_item.key_byte = key_lane_byte;
            push_item.last     = data_last;
          end else if (op_r == wsdf_pkg::OP_CLOSE && data_last) begin
            stop_nxt       = 1'b1;
            push           = 1'b1;
            push_item.kind = wsdf_pkg::EV_CLOSE;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      if (len_done) begin
        if (ovf_nxt || (CMP_W'(acc_nxt) > CMP_W'(max_len_r))) begin
          stop_nxt       = 1'b1;
          push           = 1'b1;
          push_item.kind = wsdf_pkg::EV_OVERSIZE;
        end else if (mask_nxt) begin
          ext_nxt   = wsdf_pkg::KEY_BYTES;
          phase_nxt = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        if (acc_nxt == '0) begin
          phase_nxt = PH_HDR0;
          if (op_r == wsdf_pkg::OP_CLOSE) begin
            stop_nxt       = 1'b1;
            push           = 1'b1;
            push_item.kind = wsdf_pkg::EV_CLOSE;
          end else if (op_r == wsdf_pkg::OP_TEXT || op_r == wsdf_pkg::OP_PING) begin
            push           = 1'b1;
            push_item.kind = wsdf_pkg::EV_EMPTY;
          end
        end else begin
          rem_nxt   = acc_nxt;
          lane_nxt  = 2'd0;
          phase_nxt = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      op_r      <= 4'h0;
      mask_r    <= 1'b0;
      ext_r     <= 4'h0;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      key_r     <= 32'h0;
      lane_r    <= 2'd0;
      rem_r     <= '0;
      stop_r    <= 1'b0;
      max_len_r <= wsdf_pkg::MAX_LEN_RESET;
    end else begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      mask_r  <= mask_nxt;
      ext_r   <= ext_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      key_r   <= key_nxt;
      lane_r  <= lane_nxt;
      rem_r   <= rem_nxt;
      stop_r  <= stop_nxt;
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
    end
  end

  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |-> !push)
    else $error("event pushed while parser stopped");

  a_terminal_stops: assert property (@(posedge clk) disable iff (!rst_n)
    push && (push_item.kind == wsdf_pkg::EV_CLOSE ||
             push_item.kind == wsdf_pkg::EV_OVERSIZE) |=> stop_r)
    else $error("terminal event did not stop parser");

  a_non_data_last: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_item.kind != wsdf_pkg::EV_DATA |-> push_item.last)
    else $error("non-data event without last flag");

endmodule

// File: hdl/wsdf_queue.sv
module wsdf_queue #(
  parameter int DEPTH = wsdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wsdf_pkg::ev_item_t push_item,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output wsdf_pkg::ev_item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsdf_pkg::ev_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("push into full queue");

endmodule

// File: hdl/wsdf_back.sv
module wsdf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  wsdf_pkg::ev_item_t head_item,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic [5:0]         out_tuser,
  output logic               out_tlast
);

  logic       valid_r;
  logic [7:0] data_r;
  logic [5:0] user_r;
  logic       last_r;
  logic       load;

  assign load = !valid_r || out_tready;
  assign pop  = head_valid && load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= head_valid;
    end
  end

  // unmask on the way out; non-data events carry a zero byte
  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= (head_item.kind == wsdf_pkg::EV_DATA) ?
                (head_item.rx_byte ^ head_item.key_byte) : 8'h00;
      user_r <= {head_item.opcode, head_item.kind};
      last_r <= head_item.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// File: hdl/websocket_frame_deframer.sv
// Channel   Dir  Handshake                 Payload
// -------   ---  ------------------------  ------------------------------------------
// in_       in   in_tvalid / in_tready     in_tdata[7:0] rx_byte
// out_      out  out_tvalid / out_tready   out_tdata[7:0] data_byte,
//                                          out_tuser[1:0] event_kind,
//                                          out_tuser[5:2] frame_opcode,
//                                          out_tlast frame_last
// cfg_      in   cfg_we                    cfg_wdata[15:0] max_payload_len
//
// One byte per cycle while the event queue is not full. A byte's event reaches out_tvalid
// through the queue and then the output register: the parser classifies it, the queue
// holds it, the output register unmasks it.
// Reset (rst_n low, synchronous) returns the parser to the first header byte,
// clears the stop flag and sets max_payload_len to 65535.
// in_tready drops only when the event queue is full, i.e. once QUEUE_DEPTH events
// wait behind a held output beat; header bytes and skipped payload add nothing to
// the queue. A stopped parser keeps taking beats and drops them.
module websocket_frame_deframer #(
  parameter int LEN_BITS    = wsdf_pkg::LEN_BITS_DEF,
  parameter int QUEUE_DEPTH = wsdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // receive byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  // event stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] data_byte
  output logic [5:0]  out_tuser,   // [1:0] event_kind, [5:2] frame_opcode
  output logic        out_tlast,   // frame_last
  // payload limit register
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata    // [15:0] max_payload_len
);

  logic               q_full;
  logic               byte_acc;
  logic               push;
  wsdf_pkg::ev_item_t push_item;
  logic               pop;
  logic               head_valid;
  wsdf_pkg::ev_item_t head_item;

  // Take a beat whenever the queue has room for the event it may cause
  assign in_tready = !q_full;
  assign byte_acc  = in_tvalid && in_tready;

  // Front: header parse, length check, key capture, event classification
  wsdf_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (byte_acc),
    .rx_byte   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_item (push_item)
  );

  // Short queue: let the parser run while the output side stalls
  wsdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back: unmask and hold the result beat until taken
  wsdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
